// File: hdl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// shared types, constants and the soft saturation table of the voice mixer
// ----------------------------------------------------------------------------
package svm_pkg;

   localparam int VOICE_COUNT      = 64;
   localparam int SOUND_COUNT      = 64;
   localparam int SAMPLE_ADDR_BITS = 18;

   localparam int VOICE_BITS  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int SOUND_BITS  = 6;
   localparam int SAMPLE_DEPTH = 1 << SAMPLE_ADDR_BITS;
   localparam int POS_BITS    = 35;
   localparam int STEP_BITS   = 24;
   localparam int LEN_BITS    = 19;
   localparam int ACC_BITS    = 56;
   localparam int PROD_BITS   = 49;

   // voice word: sound, position, step, left gain, right gain
   localparam int VOICE_W = SOUND_BITS + POS_BITS + STEP_BITS + 32;
   localparam int SOUND_W = SAMPLE_ADDR_BITS + LEN_BITS;

   localparam logic [LEN_BITS-1:0] MAX_LEN      = 19'd262144;
   localparam logic [15:0]         MASTER_RESET = 16'd26214;

   localparam int CSR_ADDR_BITS = 3;
   localparam logic CSR_IDX_MASTER = 1'b0;

   typedef enum logic [2:0] {
      CMD_WRITE  = 3'd0,
      CMD_DEFINE = 3'd1,
      CMD_START  = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_TICK   = 3'd4
   } cmd_code_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_CHECK, ST_SOUND, ST_LENGTH, ST_FETCH, ST_DIFF,
      ST_INTERP, ST_SCALE, ST_ACCUM, ST_NEXT, ST_MAG, ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic vcnt_clr;
      logic vcnt_inc;
      logic voice_rd;
      logic snd_rd;
      logic smp_rd0;
      logic smp_rd1;
      logic cap_s0;
      logic diff_en;
      logic interp_en;
      logic mul_en;
      logic acc_en;
      logic stop_voice;
      logic start_write;
      logic steal_write;
      logic mag_en;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic cur_active;
      logic last_voice;
      logic len_done;
      logic steal;
   } dp_status_type;

   localparam logic [15:0] TANH_TAB [0:32] = '{
      16'd0,     16'd4075,  16'd8025,  16'd11743, 16'd15143, 16'd18173,
      16'd20813, 16'd23082, 16'd24956, 16'd26519, 16'd27797, 16'd28830,
      16'd29660, 16'd30322, 16'd30847, 16'd31262, 16'd31589, 16'd31846,
      16'd32048, 16'd32206, 16'd32329, 16'd32426, 16'd32500, 16'd32558,
      16'd32606, 16'd32641, 16'd32670, 16'd32692, 16'd32708, 16'd32722,
      16'd32732, 16'd32740, 16'd32746
   };

endpackage

// File: hdl/sample_voice_mixer.sv
// ----------------------------------------------------------------------------
// sample_voice_mixer
// multi-voice sample playback mixer, linear interpolation, tanh saturation
// ----------------------------------------------------------------------------
//
//   channel   ports       handshake          beat carries
//   ------------------------------------------------------------------------
//   request   req_*       valid / stall      one command and its fields
//   result    rsp_*       valid / stall      one stereo frame per tick
//   control   csr_*       apb-style, 32 bit  master volume at byte address 0
//
// write, define and stop are all taken in the idle state; start voice scans the voice
// slots for a free one
// tick visits every slot: an idle slot is only checked, a voice that ends is
// stopped, a playing voice is fetched, interpolated, scaled and accumulated,
// and saturation follows the last slot
// reset clears voice flags, count and the sequencer and presets the master
// volume to its default; the memories are not cleared
// a finished frame waits in the output register while new commands are
// taken; a following tick holds at its last step until that frame is taken
// ----------------------------------------------------------------------------
module sample_voice_mixer import svm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_command,
   input  logic [17:0]              req_address,
   input  logic signed [15:0]       req_sample,
   input  logic [5:0]               req_sound_id,
   input  logic [18:0]              req_sound_length,
   input  logic [23:0]              req_pitch_step,
   input  logic [15:0]              req_gain_left,
   input  logic [15:0]              req_gain_right,
   input  logic                     req_steal_when_full,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [15:0]       rsp_left_out,
   output logic signed [15:0]       rsp_right_out,
   output logic [6:0]               rsp_active_count,
   // control port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          master_wr;
   logic          master_sel;
   logic [15:0]   master_volume;

   // register decode: word index sits above the byte offset
   assign master_sel = (csr_paddr[CSR_ADDR_BITS-1:2] == CSR_IDX_MASTER);
   assign master_wr  = csr_psel && csr_penable && csr_pwrite && master_sel;
   assign csr_pready = 1'b1;
   assign csr_prdata = master_sel ? {16'd0, master_volume} : 32'd0;

   // sequencer
   svm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // memories and arithmetic
   svm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_command         (req_command),
      .req_address         (req_address),
      .req_sample          (req_sample),
      .req_sound_id        (req_sound_id),
      .req_sound_length    (req_sound_length),
      .req_pitch_step      (req_pitch_step),
      .req_gain_left       (req_gain_left),
      .req_gain_right      (req_gain_right),
      .req_steal_when_full (req_steal_when_full),
      .master_wr           (master_wr),
      .master_data         (csr_pwdata[15:0]),
      .master_volume       (master_volume),
      .cmd                 (cmd),
      .status              (status),
      .rsp_left_out        (rsp_left_out),
      .rsp_right_out       (rsp_right_out),
      .rsp_active_count    (rsp_active_count)
   );

endmodule

// File: hdl/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module svm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/svm_dp.sv
// ----------------------------------------------------------------------------
// svm_dp
// mixer datapath: memories, voice flags, interpolation, gains, saturation
// ----------------------------------------------------------------------------
module svm_dp import svm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [2:0]                req_command,
   input  logic [17:0]               req_address,
   input  logic signed [15:0]        req_sample,
   input  logic [5:0]                req_sound_id,
   input  logic [18:0]               req_sound_length,
   input  logic [23:0]               req_pitch_step,
   input  logic [15:0]               req_gain_left,
   input  logic [15:0]               req_gain_right,
   input  logic                      req_steal_when_full,
   input  logic                      master_wr,
   input  logic [15:0]               master_data,
   output logic [15:0]               master_volume,
   input  ctrl_cmd_type              cmd,
   output dp_status_type             status,
   output logic signed [15:0]        rsp_left_out,
   output logic signed [15:0]        rsp_right_out,
   output logic [6:0]                rsp_active_count
);

   logic [15:0]             master_ff;
   logic [VOICE_COUNT-1:0]  active_ff;
   logic [6:0]              count_ff;
   logic [VOICE_BITS-1:0]   vcnt_ff;
   logic [SOUND_BITS-1:0]   id_ff;
   logic [STEP_BITS-1:0]    step_ff;
   logic [15:0]             gl_ff, gr_ff;
   logic                    steal_ff;

   // memories
   logic                        smp_wr, smp_rd;
   logic [SAMPLE_ADDR_BITS-1:0] smp_rd_addr;
   logic [15:0]                 smp_dout;
   logic                        snd_wr;
   logic [SOUND_W-1:0]          snd_din, snd_dout;
   logic [LEN_BITS-1:0]         len_sat;
   logic                        voice_wr;
   logic [VOICE_BITS-1:0]       voice_wr_addr;
   logic [VOICE_W-1:0]          voice_din, voice_dout;

   // voice word fields
   logic [SOUND_BITS-1:0]       v_snd;
   logic [POS_BITS-1:0]         v_pos, new_pos;
   logic [STEP_BITS-1:0]        v_step;
   logic [15:0]                 v_gl, v_gr;
   logic [LEN_BITS-1:0]         v_idx;
   logic [15:0]                 v_frac;
   logic [SAMPLE_ADDR_BITS-1:0] s_start, base, base_ff;
   logic [LEN_BITS-1:0]         s_len;

   // arithmetic pipeline
   logic signed [15:0]          s0_ff;
   logic [31:0]                 gml_ff, gmr_ff;
   logic signed [33:0]          diff_ff;
   logic signed [16:0]          delta;
   logic signed [17:0]          interp;
   logic signed [15:0]          s_ff;
   logic signed [PROD_BITS-1:0] prodl_ff, prodr_ff;
   logic signed [ACC_BITS-1:0]  accl_ff, accr_ff;
   logic [ACC_BITS-1:0]         magl_ff, magr_ff;
   logic                        negl_ff, negr_ff;
   logic signed [15:0]          outl_ff, outr_ff;
   logic [6:0]                  outc_ff;
   logic signed [15:0]          satl, satr;

   function automatic logic signed [15:0] soft_sat(input logic [ACC_BITS-1:0] mag,
                                                   input logic neg);
      logic [4:0]  seg;
      logic [15:0] lo, hi, frac, r;
      logic [31:0] prod;
      seg  = mag[45:41];
      lo   = TANH_TAB[seg];
      hi   = TANH_TAB[6'(seg) + 6'd1];
      frac = mag[40:25];
      prod = (hi - lo) * frac;
      if (|mag[ACC_BITS-1:46]) begin
         r = TANH_TAB[32];
      end else begin
         r = lo + prod[31:16];
      end
      return neg ? -$signed(r) : $signed(r);
   endfunction

   assign smp_wr  = cmd.accept && (req_command == CMD_WRITE);
   assign snd_wr  = cmd.accept && (req_command == CMD_DEFINE);
   assign len_sat = (req_sound_length > MAX_LEN) ? MAX_LEN : req_sound_length;
   assign snd_din = {req_address[SAMPLE_ADDR_BITS-1:0], len_sat};

   assign {v_snd, v_pos, v_step, v_gl, v_gr} = voice_dout;
   assign v_idx   = v_pos[POS_BITS-1:16];
   assign v_frac  = v_pos[15:0];
   assign new_pos = v_pos + POS_BITS'(v_step);
   assign {s_start, s_len} = snd_dout;
   assign base    = s_start + v_idx[SAMPLE_ADDR_BITS-1:0];

   assign smp_rd      = cmd.smp_rd0 || cmd.smp_rd1;
   assign smp_rd_addr = cmd.smp_rd1 ? base_ff + 1'b1 : base;

   assign voice_wr      = cmd.start_write || cmd.steal_write || cmd.mul_en;
   assign voice_wr_addr = cmd.steal_write ? '0 : vcnt_ff;
   assign voice_din     = cmd.mul_en ? {v_snd, new_pos, v_step, v_gl, v_gr}
                                     : {id_ff, {POS_BITS{1'b0}}, step_ff, gl_ff, gr_ff};

   svm_ram #(.WIDTH(16), .DEPTH(SAMPLE_DEPTH)) u_sample_ram (
      .clock   (clock),
      .wr_en   (smp_wr),
      .wr_addr (req_address[SAMPLE_ADDR_BITS-1:0]),
      .wr_data (req_sample),
      .rd_en   (smp_rd),
      .rd_addr (smp_rd_addr),
      .rd_data (smp_dout)
   );

   svm_ram #(.WIDTH(SOUND_W), .DEPTH(SOUND_COUNT)) u_sound_ram (
      .clock   (clock),
      .wr_en   (snd_wr),
      .wr_addr (req_sound_id),
      .wr_data (snd_din),
      .rd_en   (cmd.snd_rd),
      .rd_addr (v_snd),
      .rd_data (snd_dout)
   );

   svm_ram #(.WIDTH(VOICE_W), .DEPTH(VOICE_COUNT)) u_voice_ram (
      .clock   (clock),
      .wr_en   (voice_wr),
      .wr_addr (voice_wr_addr),
      .wr_data (voice_din),
      .rd_en   (cmd.voice_rd),
      .rd_addr (vcnt_ff),
      .rd_data (voice_dout)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= MASTER_RESET;
         active_ff <= '0;
         count_ff  <= '0;
         vcnt_ff   <= '0;
      end else begin
         if (master_wr) begin
            master_ff <= master_data;
         end
         if (cmd.vcnt_clr) begin
            vcnt_ff <= '0;
         end else if (cmd.vcnt_inc) begin
            vcnt_ff <= vcnt_ff + 1'b1;
         end
         if (cmd.accept && (req_command == CMD_STOP)) begin
            active_ff <= '0;
            count_ff  <= '0;
         end else if (cmd.start_write) begin
            active_ff[vcnt_ff] <= 1'b1;
            count_ff           <= count_ff + 1'b1;
         end else if (cmd.stop_voice) begin
            active_ff[vcnt_ff] <= 1'b0;
            count_ff           <= count_ff - 1'b1;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         id_ff    <= req_sound_id;
         step_ff  <= req_pitch_step;
         gl_ff    <= req_gain_left;
         gr_ff    <= req_gain_right;
         steal_ff <= req_steal_when_full;
      end
      if (cmd.accept && (req_command == CMD_TICK)) begin
         accl_ff <= '0;
         accr_ff <= '0;
      end else if (cmd.acc_en) begin
         accl_ff <= accl_ff + ACC_BITS'(prodl_ff);
         accr_ff <= accr_ff + ACC_BITS'(prodr_ff);
      end
      if (cmd.smp_rd0) begin
         base_ff <= base;
      end
      if (cmd.cap_s0) begin
         s0_ff  <= smp_dout;
         gml_ff <= v_gl * master_ff;
         gmr_ff <= v_gr * master_ff;
      end
      if (cmd.diff_en) begin
         diff_ff <= delta * $signed({1'b0, v_frac});
      end
      if (cmd.interp_en) begin
         s_ff <= interp[15:0];
      end
      if (cmd.mul_en) begin
         prodl_ff <= s_ff * $signed({1'b0, gml_ff});
         prodr_ff <= s_ff * $signed({1'b0, gmr_ff});
      end
      if (cmd.mag_en) begin
         magl_ff <= accl_ff[ACC_BITS-1] ? ACC_BITS'(-accl_ff) : accl_ff;
         magr_ff <= accr_ff[ACC_BITS-1] ? ACC_BITS'(-accr_ff) : accr_ff;
         negl_ff <= accl_ff[ACC_BITS-1];
         negr_ff <= accr_ff[ACC_BITS-1];
      end
      if (cmd.out_load) begin
         outl_ff <= satl;
         outr_ff <= satr;
         outc_ff <= count_ff;
      end
   end

   assign delta  = $signed({smp_dout[15], smp_dout}) - $signed({s0_ff[15], s0_ff});
   assign interp = 18'(s0_ff) + diff_ff[33:16];
   assign satl   = soft_sat(magl_ff, negl_ff);
   assign satr   = soft_sat(magr_ff, negr_ff);

   assign status.cur_active = active_ff[vcnt_ff];
   assign status.last_voice = (vcnt_ff == VOICE_BITS'(VOICE_COUNT - 1));
   assign status.len_done   = ({1'b0, v_idx} + 20'd1) >= {1'b0, s_len};
   assign status.steal      = steal_ff;

   assign master_volume    = master_ff;
   assign rsp_left_out     = outl_ff;
   assign rsp_right_out    = outr_ff;
   assign rsp_active_count = outc_ff;

endmodule

// File: hdl/svm_ctrl.sv
// ----------------------------------------------------------------------------
// svm_ctrl
// mixer sequencer: command decode, voice scan, per-voice steps, result beat
// ----------------------------------------------------------------------------
module svm_ctrl import svm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [2:0]    req_command,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_START) begin
                  state_in = ST_SCAN;
               end else if (req_command == CMD_TICK) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_SCAN: begin
            if (!status.cur_active || status.last_voice) begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            if (status.cur_active) begin
               state_in = ST_SOUND;
            end else if (status.last_voice) begin
               state_in = ST_MAG;
            end
         end
         ST_SOUND:  state_in = ST_LENGTH;
         ST_LENGTH: state_in = status.len_done ? ST_NEXT : ST_FETCH;
         ST_FETCH:  state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_INTERP;
         ST_INTERP: state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_ACCUM;
         ST_ACCUM:  state_in = ST_NEXT;
         ST_NEXT:   state_in = status.last_voice ? ST_MAG : ST_CHECK;
         ST_MAG:    state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept   = req_valid;
            cmd.vcnt_clr = req_valid;
         end
         ST_SCAN: begin
            if (!status.cur_active) begin
               cmd.start_write = 1'b1;
            end else if (status.last_voice) begin
               cmd.steal_write = status.steal;
            end else begin
               cmd.vcnt_inc = 1'b1;
            end
         end
         ST_CHECK: begin
            if (status.cur_active) begin
               cmd.voice_rd = 1'b1;
            end else if (!status.last_voice) begin
               cmd.vcnt_inc = 1'b1;
            end
         end
         ST_SOUND:  cmd.snd_rd = 1'b1;
         ST_LENGTH: begin
            cmd.stop_voice = status.len_done;
            cmd.smp_rd0    = !status.len_done;
         end
         ST_FETCH: begin
            cmd.smp_rd1 = 1'b1;
            cmd.cap_s0  = 1'b1;
         end
         ST_DIFF:   cmd.diff_en   = 1'b1;
         ST_INTERP: cmd.interp_en = 1'b1;
         ST_SCALE:  cmd.mul_en    = 1'b1;
         ST_ACCUM:  cmd.acc_en    = 1'b1;
         ST_NEXT:   cmd.vcnt_inc  = !status.last_voice;
         ST_MAG:    cmd.mag_en    = 1'b1;
         ST_OUT:    cmd.out_load  = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
